FILE: hdl/otsr_pkg.sv
// Package for the single-wire temperature sensor reader.
// Holds the sequencer phase type, result record, register indexes and command bytes.
// No dependencies.
package otsr_pkg;

  localparam int unsigned TickW = 20;
  localparam int unsigned CfgW  = 20;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_PRES    = 4'd2,
    PH_POST    = 4'd3,
    PH_W_LOW   = 4'd4,
    PH_W_HOLD  = 4'd5,
    PH_W_REC   = 4'd6,
    PH_CONVERT = 4'd7,
    PH_R_LOW   = 4'd8,
    PH_R_WAIT  = 4'd9,
    PH_R_REST  = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW    = 3'd0,
    CFG_PRES_TIMEOUT = 3'd1,
    CFG_POST_INIT    = 3'd2,
    CFG_WRITE_HOLD   = 3'd3,
    CFG_READ_SAMPLE  = 3'd4,
    CFG_READ_REST    = 3'd5,
    CFG_CONVERT_WAIT = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] CmdSkipRom   = 8'hcc;
  localparam logic [7:0] CmdConvert   = 8'h44;
  localparam logic [7:0] CmdReadPad   = 8'hbe;

  localparam logic [2:0] ByteConvDone = 3'd2;
  localparam logic [2:0] ByteReadLow  = 3'd4;
  localparam logic [2:0] ByteReadHigh = 3'd5;
  localparam logic [2:0] LastBit      = 3'd7;

  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    logic               no_presence;
    logic signed [15:0] temperature_raw;
  } res_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CmdSkipRom;
      2'd1:    b = CmdConvert;
      2'd2:    b = CmdSkipRom;
      default: b = CmdReadPad;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/onewire_temp_sensor_reader.sv
// Single-wire bus master that runs a temperature measurement sequence, one tick per item.
// Sequencer state, timing registers and a two-entry output stage; uses otsr_pkg.
// Each accepted result is registered in out_q, or in skid_q while the output stalls.
// Throughput: one item per clock unless stalled; the phase steps once per accepted tick.
// Output stage is a result register plus a skid register, so stall_o is registered.
// Reset: sequencer idle, counters and flags zero, timing registers at their defaults,
// no result held.
module onewire_temp_sensor_reader
  import otsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               start_req_i,
  input  logic               line_level_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               no_presence_o,
  output logic signed [15:0] temperature_raw_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [15:0] rst_low_q, pres_to_q, post_q, hold_q, sample_q, rest_q;
  logic [TickW-1:0] conv_q;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]       bit_q, bit_d, byte_q, byte_d, byte_n;
  logic [7:0]       shift_q, shift_d, low_q, low_d;
  logic [15:0]      temp_q, temp_d;
  logic             pres_q, pres_d;

  logic [TickW-1:0] rst_len, hold_len, sample_len;
  logic             load_cmd, enter_post, after_read, done_d;

  res_t res_new;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic in_acc, out_ready;

  assign in_acc    = valid_i && !stall_o;
  assign out_ready = !out_valid_q || !stall_i;
  assign stall_o   = skid_valid_q;

  assign tick_inc   = tick_q + TickW'(1);
  assign rst_len    = (rst_low_q == '0) ? TickW'(1) : TickW'(rst_low_q);
  assign hold_len   = (hold_q == '0) ? TickW'(1) : TickW'(hold_q);
  assign sample_len = (sample_q == '0) ? TickW'(1) : TickW'(sample_q);
  assign byte_n     = byte_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q <= 16'd642;
      pres_to_q <= 16'd5000;
      post_q    <= 16'd1000;
      hold_q    <= 16'd68;
      sample_q  <= 16'd6;
      rest_q    <= 16'd48;
      conv_q    <= TickW'(100000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESET_LOW:    rst_low_q <= cfg_data_i[15:0];
        CFG_PRES_TIMEOUT: pres_to_q <= cfg_data_i[15:0];
        CFG_POST_INIT:    post_q    <= cfg_data_i[15:0];
        CFG_WRITE_HOLD:   hold_q    <= cfg_data_i[15:0];
        CFG_READ_SAMPLE:  sample_q  <= cfg_data_i[15:0];
        CFG_READ_REST:    rest_q    <= cfg_data_i[15:0];
        CFG_CONVERT_WAIT: conv_q    <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    byte_d     = byte_q;
    shift_d    = shift_q;
    low_d      = low_q;
    temp_d     = temp_q;
    pres_d     = pres_q;
    load_cmd   = 1'b0;
    enter_post = 1'b0;
    after_read = 1'b0;
    done_d     = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          pres_d  = 1'b0;
          byte_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          phase_d = PH_RST_LOW;
          tick_d  = '0;
        end
      end
      PH_RST_LOW: begin
        tick_d = tick_inc;
        if (tick_inc >= rst_len) begin
          phase_d = PH_PRES;
          tick_d  = '0;
        end
      end
      PH_PRES: begin
        if (!line_level_i) begin
          enter_post = 1'b1;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= TickW'(pres_to_q)) begin
            pres_d     = 1'b1;
            enter_post = 1'b1;
          end
        end
      end
      PH_POST: begin
        tick_d = tick_inc;
        if (tick_inc >= TickW'(post_q)) load_cmd = 1'b1;
      end
      PH_W_LOW: begin
        phase_d = PH_W_HOLD;
        tick_d  = '0;
      end
      PH_W_HOLD: begin
        tick_d = tick_inc;
        if (tick_inc >= hold_len) begin
          phase_d = PH_W_REC;
          tick_d  = '0;
        end
      end
      PH_W_REC: begin
        if (bit_q < LastBit) begin
          bit_d   = bit_q + 3'd1;
          shift_d = shift_q >> 1;
          phase_d = PH_W_LOW;
          tick_d  = '0;
        end else begin
          byte_d = byte_n;
          if (byte_n == ByteConvDone) begin
            phase_d = (conv_q == '0) ? PH_RST_LOW : PH_CONVERT;
            tick_d  = '0;
          end else if (byte_n >= ByteReadLow) begin
            byte_d  = ByteReadLow;
            shift_d = '0;
            bit_d   = '0;
            phase_d = PH_R_LOW;
            tick_d  = '0;
          end else begin
            load_cmd = 1'b1;
          end
        end
      end
      PH_CONVERT: begin
        tick_d = tick_inc;
        if (tick_inc >= conv_q) begin
          phase_d = PH_RST_LOW;
          tick_d  = '0;
        end
      end
      PH_R_LOW: begin
        phase_d = PH_R_WAIT;
        tick_d  = '0;
      end
      PH_R_WAIT: begin
        tick_d = tick_inc;
        if (tick_inc >= sample_len) begin
          shift_d = {line_level_i, shift_q[7:1]};
          if (rest_q == '0) begin
            after_read = 1'b1;
          end else begin
            phase_d = PH_R_REST;
            tick_d  = '0;
          end
        end
      end
      PH_R_REST: begin
        tick_d = tick_inc;
        if (tick_inc >= TickW'(rest_q)) after_read = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase

    if (enter_post) begin
      if (post_q == '0) begin
        load_cmd = 1'b1;
      end else begin
        phase_d = PH_POST;
        tick_d  = '0;
      end
    end

    if (load_cmd) begin
      shift_d = cmd_byte(byte_d[1:0]);
      bit_d   = '0;
      phase_d = PH_W_LOW;
      tick_d  = '0;
    end

    if (after_read) begin
      tick_d = '0;
      if (bit_q < LastBit) begin
        bit_d   = bit_q + 3'd1;
        phase_d = PH_R_LOW;
      end else if (byte_q == ByteReadLow) begin
        low_d   = shift_d;
        byte_d  = ByteReadHigh;
        bit_d   = '0;
        shift_d = '0;
        phase_d = PH_R_LOW;
      end else begin
        temp_d  = {shift_d, low_q};
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
    end

    res_new.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) ||
                        (phase_d == PH_R_LOW) || ((phase_d == PH_W_HOLD) && !shift_d[0]);
    res_new.busy            = (phase_d != PH_IDLE);
    res_new.done            = done_d;
    res_new.no_presence     = pres_d;
    res_new.temperature_raw = temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      low_q   <= '0;
      temp_q  <= '0;
      pres_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      low_q   <= low_d;
      temp_q  <= temp_d;
      pres_q  <= pres_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= skid_valid_q && in_acc;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_acc) skid_q <= res_new;
      end else if (in_acc) begin
        out_q <= res_new;
      end
    end else if (in_acc) begin
      skid_q <= res_new;
    end
  end

  assign valid_o           = out_valid_q;
  assign drive_low_o       = out_q.drive_low;
  assign busy_res_o        = out_q.busy;
  assign done_res_o        = out_q.done;
  assign no_presence_o     = out_q.no_presence;
  assign temperature_raw_o = out_q.temperature_raw;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in front of it");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done |-> !out_q.busy)
    else $error("done shown while the sequence is still busy");

  a_drive_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.drive_low |-> out_q.busy)
    else $error("line driven low while idle");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (phase_q == PH_IDLE) && !start_req_i |=> phase_q == PH_IDLE)
    else $error("sequencer left idle without a start");

  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done_d |-> (byte_q == ByteReadHigh) && (bit_q == LastBit))
    else $error("value stored before the last read bit");

endmodule
